/* hdl/xeu_pkg.sv */
// shared constants and types of the x86 subset execute unit
package xeu_pkg;

   localparam int MEM_ADDR_BITS_DEFAULT = 16;

   // operation codes
   localparam logic [2:0] OP_MOV  = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_CMP  = 3'd3;
   localparam logic [2:0] OP_JNZ  = 3'd4;
   localparam logic [2:0] OP_LOOP = 3'd5;

   // destination kinds, codes above DK_DIRECT mean no destination
   localparam logic [2:0] DK_REG    = 3'd0;
   localparam logic [2:0] DK_SREG   = 3'd1;
   localparam logic [2:0] DK_EA     = 3'd2;
   localparam logic [2:0] DK_DIRECT = 3'd3;

   // source kinds, codes above SK_DIRECT mean no source
   localparam logic [2:0] SK_REG    = 3'd0;
   localparam logic [2:0] SK_SREG   = 3'd1;
   localparam logic [2:0] SK_IMM    = 3'd2;
   localparam logic [2:0] SK_EA     = 3'd3;
   localparam logic [2:0] SK_DIRECT = 3'd4;

   // effective address base combinations
   localparam logic [2:0] BASE_BX_SI = 3'd0;
   localparam logic [2:0] BASE_BX_DI = 3'd1;
   localparam logic [2:0] BASE_BP_SI = 3'd2;
   localparam logic [2:0] BASE_BP_DI = 3'd3;
   localparam logic [2:0] BASE_SI    = 3'd4;
   localparam logic [2:0] BASE_DI    = 3'd5;
   localparam logic [2:0] BASE_BP    = 3'd6;
   localparam logic [2:0] BASE_BX    = 3'd7;

   // general register numbers
   localparam logic [2:0] REG_CX = 3'd1;
   localparam logic [2:0] REG_BX = 3'd3;
   localparam logic [2:0] REG_BP = 3'd5;
   localparam logic [2:0] REG_SI = 3'd6;
   localparam logic [2:0] REG_DI = 3'd7;

   // flag bit positions
   localparam int FLAG_PF = 2;
   localparam int FLAG_ZF = 6;
   localparam int FLAG_SF = 7;

   localparam logic [15:0] WORD_MASK = 16'hFFFF;
   localparam logic [15:0] BYTE_MASK = 16'h00FF;

   // data memory access control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_word;
   } dmem_ctl_type;

endpackage

/* hdl/xeu_if.sv */
// valid/ready channels for decoded instructions and execution results
interface xeu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic        wide;
   logic [2:0]  dest_kind;
   logic [2:0]  dest_reg;
   logic [2:0]  dest_base;
   logic [15:0] dest_disp;
   logic [2:0]  src_kind;
   logic [2:0]  src_reg;
   logic [2:0]  src_base;
   logic [15:0] src_disp;
   logic [15:0] immediate;
   logic [15:0] next_ip;

   modport source (
      output valid, req_type, wide, dest_kind, dest_reg, dest_base, dest_disp,
             src_kind, src_reg, src_base, src_disp, immediate, next_ip,
      input  ready
   );
   modport sink (
      input  valid, req_type, wide, dest_kind, dest_reg, dest_base, dest_disp,
             src_kind, src_reg, src_base, src_disp, immediate, next_ip,
      output ready
   );
endinterface

interface xeu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] new_ip;
   logic [15:0] flags_word;
   logic [15:0] result_value;
   logic        dest_written;
   logic        branch_taken;

   modport source (
      output valid, new_ip, flags_word, result_value, dest_written, branch_taken,
      input  ready
   );
   modport sink (
      input  valid, new_ip, flags_word, result_value, dest_written, branch_taken,
      output ready
   );
endinterface

/* hdl/xeu_dmem.sv */
// byte data memory in even/odd banks, two operand reads, one byte or word write
module xeu_dmem #(
   parameter int ADDR_BITS = xeu_pkg::MEM_ADDR_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  xeu_pkg::dmem_ctl_type  ctl,
   input  logic [ADDR_BITS-1:0]   rd_src_addr,
   input  logic [ADDR_BITS-1:0]   rd_dst_addr,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [15:0]            wr_data,
   output logic [15:0]            rd_src_word,
   output logic [15:0]            rd_dst_word,
   output logic                   busy
);
   import xeu_pkg::*;

   localparam int IdxBits = ADDR_BITS - 1;
   localparam int Depth   = 2 ** IdxBits;

   logic [7:0] even_mem [Depth];
   logic [7:0] odd_mem  [Depth];

   logic               busy_ff, busy_in;
   logic [IdxBits-1:0] clr_idx_ff, clr_idx_in;

   logic               we_even, we_odd;
   logic [IdxBits-1:0] widx_even, widx_odd;
   logic [7:0]         wdat_even, wdat_odd;
   logic               nwe_even, nwe_odd;
   logic [IdxBits-1:0] nwidx_even;
   logic [7:0]         nwdat_even, nwdat_odd;

   logic [IdxBits-1:0] src_even_idx, dst_even_idx;
   logic [7:0]         src_even_q_ff, src_odd_q_ff, dst_even_q_ff, dst_odd_q_ff;
   logic [IdxBits-1:0] src_even_idx_ff, src_odd_idx_ff, dst_even_idx_ff, dst_odd_idx_ff;
   logic               src_lsb_ff, dst_lsb_ff;
   logic               fwd_even_en_ff, fwd_odd_en_ff;
   logic [IdxBits-1:0] fwd_even_idx_ff, fwd_odd_idx_ff;
   logic [7:0]         fwd_even_data_ff, fwd_odd_data_ff;
   logic [7:0]         s_even, s_odd, d_even, d_odd;

   // an odd address puts its high byte in the next even row
   function automatic logic [IdxBits-1:0] even_index(input logic [ADDR_BITS-1:0] a);
      return a[0] ? a[ADDR_BITS-1:1] + IdxBits'(1) : a[ADDR_BITS-1:1];
   endfunction

   // zero sweep after reset, one row of both banks per cycle
   always_comb begin
      busy_in    = busy_ff && (clr_idx_ff != {IdxBits{1'b1}});
      clr_idx_in = busy_ff ? clr_idx_ff + IdxBits'(1) : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   assign busy = busy_ff;

   always_comb begin
      nwe_even   = ctl.wr_en && (ctl.wr_word || !wr_addr[0]);
      nwe_odd    = ctl.wr_en && (ctl.wr_word || wr_addr[0]);
      nwidx_even = even_index(wr_addr);
      nwdat_even = wr_addr[0] ? wr_data[15:8] : wr_data[7:0];
      nwdat_odd  = wr_addr[0] ? wr_data[7:0] : wr_data[15:8];
      if (busy_ff) begin
         we_even   = 1'b1;
         we_odd    = 1'b1;
         widx_even = clr_idx_ff;
         widx_odd  = clr_idx_ff;
         wdat_even = 8'h00;
         wdat_odd  = 8'h00;
      end else begin
         we_even   = nwe_even;
         we_odd    = nwe_odd;
         widx_even = nwidx_even;
         widx_odd  = wr_addr[ADDR_BITS-1:1];
         wdat_even = nwdat_even;
         wdat_odd  = nwdat_odd;
      end
   end

   always_ff @(posedge clock) begin
      if (we_even) begin
         even_mem[widx_even] <= wdat_even;
      end
      if (we_odd) begin
         odd_mem[widx_odd] <= wdat_odd;
      end
   end

   assign src_even_idx = even_index(rd_src_addr);
   assign dst_even_idx = even_index(rd_dst_addr);

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         src_even_q_ff <= even_mem[src_even_idx];
         src_odd_q_ff  <= odd_mem[rd_src_addr[ADDR_BITS-1:1]];
         dst_even_q_ff <= even_mem[dst_even_idx];
         dst_odd_q_ff  <= odd_mem[rd_dst_addr[ADDR_BITS-1:1]];
      end
   end

   // read address and the write of the same edge, kept for forwarding
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         src_even_idx_ff  <= src_even_idx;
         src_odd_idx_ff   <= rd_src_addr[ADDR_BITS-1:1];
         dst_even_idx_ff  <= dst_even_idx;
         dst_odd_idx_ff   <= rd_dst_addr[ADDR_BITS-1:1];
         src_lsb_ff       <= rd_src_addr[0];
         dst_lsb_ff       <= rd_dst_addr[0];
         fwd_even_idx_ff  <= nwidx_even;
         fwd_odd_idx_ff   <= wr_addr[ADDR_BITS-1:1];
         fwd_even_data_ff <= nwdat_even;
         fwd_odd_data_ff  <= nwdat_odd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_even_en_ff <= 1'b0;
         fwd_odd_en_ff  <= 1'b0;
      end else if (ctl.rd_en) begin
         fwd_even_en_ff <= nwe_even;
         fwd_odd_en_ff  <= nwe_odd;
      end
   end

   always_comb begin
      s_even = (fwd_even_en_ff && fwd_even_idx_ff == src_even_idx_ff) ?
               fwd_even_data_ff : src_even_q_ff;
      s_odd  = (fwd_odd_en_ff && fwd_odd_idx_ff == src_odd_idx_ff) ?
               fwd_odd_data_ff : src_odd_q_ff;
      d_even = (fwd_even_en_ff && fwd_even_idx_ff == dst_even_idx_ff) ?
               fwd_even_data_ff : dst_even_q_ff;
      d_odd  = (fwd_odd_en_ff && fwd_odd_idx_ff == dst_odd_idx_ff) ?
               fwd_odd_data_ff : dst_odd_q_ff;
      rd_src_word = src_lsb_ff ? {s_even, s_odd} : {s_odd, s_even};
      rd_dst_word = dst_lsb_ff ? {d_even, d_odd} : {d_odd, d_even};
   end

endmodule

/* hdl/x86_subset_execute_unit.sv */
// path: accepted transaction -> address register -> execute register -> output register
// throughput: one instruction per cycle unless the output stalls; an instruction that
//   builds an effective address waits while a general register write is in execute
// reset: registers and flags clear at once; the data memory is swept to zero, one
//   even/odd row pair a cycle, and req_bus.ready stays low until the sweep ends
module x86_subset_execute_unit #(
   parameter int MEM_ADDR_BITS = xeu_pkg::MEM_ADDR_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   xeu_req_if.sink   req_bus,
   xeu_rsp_if.source rsp_bus
);
   import xeu_pkg::*;

   typedef struct packed {
      logic [2:0]  req_type;
      logic        wide;
      logic [2:0]  dest_kind;
      logic [2:0]  dest_reg;
      logic [2:0]  dest_base;
      logic [15:0] dest_disp;
      logic [2:0]  src_kind;
      logic [2:0]  src_reg;
      logic [2:0]  src_base;
      logic [15:0] src_disp;
      logic [15:0] immediate;
      logic [15:0] next_ip;
   } req_item_type;

   req_item_type req_item;
   req_item_type a_item_ff, a_item_in, b_item_ff, b_item_in;
   logic a_valid_ff, a_valid_in, b_valid_ff, b_valid_in, out_valid_ff, out_valid_in;
   logic [MEM_ADDR_BITS-1:0] b_daddr_ff, b_daddr_in;

   logic [15:0] gpr_ff [8];
   logic [15:0] gpr_in [8];
   logic [15:0] seg_ff [4];
   logic [15:0] seg_in [4];
   logic        zf_ff, zf_in, sf_ff, sf_in, pf_ff, pf_in;

   logic [15:0] out_new_ip_ff, out_new_ip_in, out_flags_ff, out_flags_in;
   logic [15:0] out_result_ff, out_result_in;
   logic        out_written_ff, out_written_in, out_taken_ff, out_taken_in;

   logic        accept, a_move, b_fire, hazard, a_uses_ea, b_wr_gpr, mem_busy;
   logic [15:0] a_daddr16, a_saddr16;
   logic [MEM_ADDR_BITS-1:0] a_daddr, a_saddr;

   dmem_ctl_type dmem_ctl;
   logic [15:0]  src_word, dst_word;

   logic        w;
   logic [15:0] mask, dval, sval, res, new_ip;
   logic        written, taken, mem_write;
   logic [15:0] flags_word;

   function automatic logic [15:0] ea_base(input logic [2:0] base);
      logic [15:0] v;
      case (base)
         BASE_BX_SI: v = gpr_ff[REG_BX] + gpr_ff[REG_SI];
         BASE_BX_DI: v = gpr_ff[REG_BX] + gpr_ff[REG_DI];
         BASE_BP_SI: v = gpr_ff[REG_BP] + gpr_ff[REG_SI];
         BASE_BP_DI: v = gpr_ff[REG_BP] + gpr_ff[REG_DI];
         BASE_SI:    v = gpr_ff[REG_SI];
         BASE_DI:    v = gpr_ff[REG_DI];
         BASE_BP:    v = gpr_ff[REG_BP];
         default:    v = gpr_ff[REG_BX];
      endcase
      return v;
   endfunction

   // byte registers 4-7 are the high halves of ax, cx, dx, bx
   function automatic logic [15:0] gpr_read(input logic [2:0] r, input logic wd);
      logic [15:0] v;
      if (wd) begin
         v = gpr_ff[r];
      end else if (!r[2]) begin
         v = gpr_ff[r] & BYTE_MASK;
      end else begin
         v = {8'h00, gpr_ff[{1'b0, r[1:0]}][15:8]};
      end
      return v;
   endfunction

   assign req_item = '{
      req_type:  req_bus.req_type,
      wide:      req_bus.wide,
      dest_kind: req_bus.dest_kind,
      dest_reg:  req_bus.dest_reg,
      dest_base: req_bus.dest_base,
      dest_disp: req_bus.dest_disp,
      src_kind:  req_bus.src_kind,
      src_reg:   req_bus.src_reg,
      src_base:  req_bus.src_base,
      src_disp:  req_bus.src_disp,
      immediate: req_bus.immediate,
      next_ip:   req_bus.next_ip
   };

   // address stage
   always_comb begin
      a_daddr16 = (a_item_ff.dest_kind == DK_EA) ?
                  ea_base(a_item_ff.dest_base) + a_item_ff.dest_disp : a_item_ff.dest_disp;
      a_saddr16 = (a_item_ff.src_kind == SK_EA) ?
                  ea_base(a_item_ff.src_base) + a_item_ff.src_disp : a_item_ff.src_disp;
      a_daddr   = MEM_ADDR_BITS'(a_daddr16);
      a_saddr   = MEM_ADDR_BITS'(a_saddr16);
      a_uses_ea = (a_item_ff.dest_kind == DK_EA) || (a_item_ff.src_kind == SK_EA);
      b_wr_gpr  = b_valid_ff && (b_item_ff.dest_kind == DK_REG) &&
                  (b_item_ff.req_type == OP_MOV || b_item_ff.req_type == OP_ADD ||
                   b_item_ff.req_type == OP_SUB);
      // base registers are read here, so wait for a pending register write
      hazard    = a_uses_ea && b_wr_gpr;
   end

   assign b_fire        = b_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign a_move        = a_valid_ff && !hazard && (!b_valid_ff || b_fire);
   assign req_bus.ready = !mem_busy && (!a_valid_ff || a_move);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      a_valid_in = accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      a_item_in  = accept ? req_item : a_item_ff;
      b_valid_in = a_move ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
      b_item_in  = a_move ? a_item_ff : b_item_ff;
      b_daddr_in = a_move ? a_daddr : b_daddr_ff;
   end

   // execute stage
   always_comb begin
      w    = b_item_ff.wide || (b_item_ff.dest_kind == DK_SREG) ||
             (b_item_ff.src_kind == SK_SREG);
      mask = w ? WORD_MASK : BYTE_MASK;

      case (b_item_ff.dest_kind)
         DK_REG:    dval = gpr_read(b_item_ff.dest_reg, w);
         DK_SREG:   dval = seg_ff[b_item_ff.dest_reg[1:0]];
         DK_EA,
         DK_DIRECT: dval = dst_word & mask;
         default:   dval = 16'h0000;
      endcase

      case (b_item_ff.src_kind)
         SK_REG:    sval = gpr_read(b_item_ff.src_reg, w);
         SK_SREG:   sval = seg_ff[b_item_ff.src_reg[1:0]];
         SK_IMM:    sval = b_item_ff.immediate & mask;
         SK_EA,
         SK_DIRECT: sval = src_word & mask;
         default:   sval = 16'h0000;
      endcase

      res       = 16'h0000;
      written   = 1'b0;
      taken     = 1'b0;
      mem_write = 1'b0;
      zf_in     = zf_ff;
      sf_in     = sf_ff;
      pf_in     = pf_ff;
      gpr_in    = gpr_ff;
      seg_in    = seg_ff;

      case (b_item_ff.req_type)
         OP_MOV, OP_ADD, OP_SUB, OP_CMP: begin
            case (b_item_ff.req_type)
               OP_MOV:  res = sval;
               OP_ADD:  res = (dval + sval) & mask;
               default: res = (dval - sval) & mask;
            endcase
            if (b_item_ff.req_type != OP_MOV) begin
               zf_in = (res == 16'h0000);
               pf_in = ~(^res[7:0]);
               sf_in = w ? res[15] : res[7];
            end
            if (b_item_ff.req_type != OP_CMP) begin
               case (b_item_ff.dest_kind)
                  DK_REG: begin
                     written = 1'b1;
                     if (w) begin
                        gpr_in[b_item_ff.dest_reg] = res;
                     end else if (!b_item_ff.dest_reg[2]) begin
                        gpr_in[b_item_ff.dest_reg][7:0] = res[7:0];
                     end else begin
                        gpr_in[{1'b0, b_item_ff.dest_reg[1:0]}][15:8] = res[7:0];
                     end
                  end
                  DK_SREG: begin
                     written = 1'b1;
                     seg_in[b_item_ff.dest_reg[1:0]] = res;
                  end
                  DK_EA, DK_DIRECT: begin
                     written   = 1'b1;
                     mem_write = 1'b1;
                  end
                  default: written = 1'b0;
               endcase
            end
         end
         OP_JNZ: begin
            taken = !zf_ff;
         end
         OP_LOOP: begin
            res             = gpr_ff[REG_CX] - 16'd1;
            gpr_in[REG_CX]  = res;
            written         = 1'b1;
            taken           = (res != 16'h0000);
         end
         default: res = 16'h0000;
      endcase

      new_ip     = taken ? b_item_ff.immediate : b_item_ff.next_ip;
      flags_word = 16'h0000;
      flags_word[FLAG_ZF] = zf_in;
      flags_word[FLAG_SF] = sf_in;
      flags_word[FLAG_PF] = pf_in;
   end

   always_comb begin
      dmem_ctl.rd_en   = a_move;
      dmem_ctl.wr_en   = b_fire && mem_write;
      dmem_ctl.wr_word = w;
   end

   xeu_dmem #(
      .ADDR_BITS(MEM_ADDR_BITS)
   ) u_dmem (
      .clock       (clock),
      .reset       (reset),
      .ctl         (dmem_ctl),
      .rd_src_addr (a_saddr),
      .rd_dst_addr (a_daddr),
      .wr_addr     (b_daddr_ff),
      .wr_data     (res),
      .rd_src_word (src_word),
      .rd_dst_word (dst_word),
      .busy        (mem_busy)
   );

   // output register
   always_comb begin
      out_valid_in   = b_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
      out_new_ip_in  = b_fire ? new_ip : out_new_ip_ff;
      out_flags_in   = b_fire ? flags_word : out_flags_ff;
      out_result_in  = b_fire ? res : out_result_ff;
      out_written_in = b_fire ? written : out_written_ff;
      out_taken_in   = b_fire ? taken : out_taken_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         zf_ff        <= 1'b0;
         sf_ff        <= 1'b0;
         pf_ff        <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            gpr_ff[i] <= 16'h0000;
         end
         for (int i = 0; i < 4; i++) begin
            seg_ff[i] <= 16'h0000;
         end
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         if (b_fire) begin
            zf_ff  <= zf_in;
            sf_ff  <= sf_in;
            pf_ff  <= pf_in;
            gpr_ff <= gpr_in;
            seg_ff <= seg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff      <= a_item_in;
      b_item_ff      <= b_item_in;
      b_daddr_ff     <= b_daddr_in;
      out_new_ip_ff  <= out_new_ip_in;
      out_flags_ff   <= out_flags_in;
      out_result_ff  <= out_result_in;
      out_written_ff <= out_written_in;
      out_taken_ff   <= out_taken_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.new_ip       = out_new_ip_ff;
   assign rsp_bus.flags_word   = out_flags_ff;
   assign rsp_bus.result_value = out_result_ff;
   assign rsp_bus.dest_written = out_written_ff;
   assign rsp_bus.branch_taken = out_taken_ff;

endmodule
